[rtl/tsbd_pkg.sv]
// Shared types, constants and channel expansion helpers for the texel decoder.
package tsbd_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;
    localparam int DEFAULT_TILE_SIDE     = 32;

    localparam int TEXEL_W    = 32;
    localparam int INDEX_W    = 24;
    localparam int CHANNEL_W  = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int FORMAT_W   = 2;
    localparam int DIM_REG_W  = 13;
    localparam int PITCH_REG_W = 14;

    typedef enum logic [FORMAT_W-1:0] {
        FMT_RGBA8888 = 2'd0,
        FMT_RGBA4444 = 2'd1,
        FMT_RGB565   = 2'd2,
        FMT_RGBA5551 = 2'd3
    } pixel_format_t;

    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TILED_LAYOUT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_PITCH    = 3'd4;

    localparam logic [CHANNEL_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHANNEL_W-1:0] ALPHA_CLEAR  = 8'h00;

    function automatic logic [CHANNEL_W-1:0] rep4(input logic [3:0] t);
        rep4 = {t, t};
    endfunction

    function automatic logic [CHANNEL_W-1:0] rep5(input logic [4:0] t);
        rep5 = {t, t[4:2]};
    endfunction

    function automatic logic [CHANNEL_W-1:0] rep6(input logic [5:0] t);
        rep6 = {t, t[5:4]};
    endfunction

endpackage

[rtl/texel_stream_to_bgra_decoder_core.sv]
// Texel word to BGRA8888 pixel decoder with linear and tiled address walk.
//
// Input channel s_*: one stored texel word per handshake, in storage order.
// Output channel m_*: one BGRA8888 pixel with its bitmap index for every kept
// word; words past the row width (linear) or outside the image (tiled) are
// dropped and give no output. m_image_end marks the last pixel of the image.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata while the
// block is idle; any write to a defined register restarts the image walk.
//
// Pipeline: two register stages; a kept word is registered in the input stage
// when accepted and moves on when the output stage is free. The input stage
// holds the position and keep flag, the output stage the decoded channels and
// row * width + column from one multiply-add.
// Throughput: one word per cycle, sustained, as long as m_ready stays high;
// the position counters update once per accepted word.
// When m_ready is low, the output register holds its word and the input
// stage may still take one more word; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages, zeroes the walk
// counters and loads RGBA4444, linear, 1x1 image, pitch 1.
module texel_stream_to_bgra_decoder_core #(
    parameter int MAX_DIMENSION = tsbd_pkg::DEFAULT_MAX_DIMENSION,
    parameter int TILE_SIDE     = tsbd_pkg::DEFAULT_TILE_SIDE
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [tsbd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tsbd_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tsbd_pkg::TEXEL_W-1:0]       s_texel_word,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tsbd_pkg::INDEX_W-1:0]       m_pixel_index,
    output logic [tsbd_pkg::CHANNEL_W-1:0]     m_blue,
    output logic [tsbd_pkg::CHANNEL_W-1:0]     m_green,
    output logic [tsbd_pkg::CHANNEL_W-1:0]     m_red,
    output logic [tsbd_pkg::CHANNEL_W-1:0]     m_alpha,
    output logic                               m_image_end
);

    localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int POS_W   = $clog2(MAX_DIMENSION);
    localparam int TILE_W  = $clog2(TILE_SIDE);
    localparam int ROW_W   = (POS_W > TILE_W) ? POS_W : TILE_W;
    localparam int COL_W   = $clog2(2 * MAX_DIMENSION);
    localparam int PITCH_W = $clog2(2 * MAX_DIMENSION + 1);
    localparam int CMP_W   = (COL_W + 2 > tsbd_pkg::CFG_DATA_W + 1) ?
                             COL_W + 2 : tsbd_pkg::CFG_DATA_W + 1;
    localparam int IDX_W   = POS_W + DIM_W + 1;
    localparam int AREA_W  = 2 * DIM_W;

    // configuration registers
    tsbd_pkg::pixel_format_t                format_reg;
    logic                                   tiled_reg;
    logic [tsbd_pkg::DIM_REG_W-1:0]         width_reg;
    logic [tsbd_pkg::DIM_REG_W-1:0]         height_reg;
    logic [tsbd_pkg::PITCH_REG_W-1:0]       pitch_reg;

    // walk counters
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [POS_W-1:0]  tcb_reg,  tcb_next;
    logic [POS_W-1:0]  trb_reg,  trb_next;

    // input stage
    logic                           s1_valid_reg;
    logic [tsbd_pkg::TEXEL_W-1:0]   s1_word_reg;
    logic [POS_W-1:0]               s1_x_reg;
    logic [POS_W-1:0]               s1_y_reg;

    // output stage
    logic                           m_valid_reg;
    logic [tsbd_pkg::INDEX_W-1:0]   m_index_reg;
    logic [tsbd_pkg::CHANNEL_W-1:0] m_blue_reg, m_green_reg, m_red_reg, m_alpha_reg;
    logic                           m_end_reg;

    logic [DIM_W-1:0]   w_clamp, h_clamp;
    logic [PITCH_W-1:0] pitch_eff;
    logic               s_accept, s1_advance, out_free, cfg_hit;
    logic [CMP_W-1:0]   x_wide, y_wide;
    logic               keep;

    logic [tsbd_pkg::CHANNEL_W-1:0] dec_b, dec_g, dec_r, dec_a;
    logic [IDX_W-1:0]               index_full;

    // ---------------- effective dimensions ----------------
    always_comb begin
        if (width_reg == '0) begin
            w_clamp = DIM_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_DIMENSION)) begin
            w_clamp = DIM_W'(MAX_DIMENSION);
        end else begin
            w_clamp = DIM_W'(width_reg);
        end

        if (height_reg == '0) begin
            h_clamp = DIM_W'(1);
        end else if (CMP_W'(height_reg) > CMP_W'(MAX_DIMENSION)) begin
            h_clamp = DIM_W'(MAX_DIMENSION);
        end else begin
            h_clamp = DIM_W'(height_reg);
        end

        if (CMP_W'(pitch_reg) < CMP_W'(w_clamp)) begin
            pitch_eff = PITCH_W'(w_clamp);
        end else if (CMP_W'(pitch_reg) > CMP_W'(2 * MAX_DIMENSION)) begin
            pitch_eff = PITCH_W'(2 * MAX_DIMENSION);
        end else begin
            pitch_eff = PITCH_W'(pitch_reg);
        end
    end

    // ---------------- handshake ----------------
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign s_accept   = s_valid && s_ready;
    assign cfg_hit    = cfg_wr_en && (cfg_addr <= tsbd_pkg::REG_ROW_PITCH);

    // ---------------- position and walk ----------------
    always_comb begin
        if (tiled_reg) begin
            x_wide = CMP_W'(tcb_reg) + CMP_W'(col_reg);
            y_wide = CMP_W'(trb_reg) + CMP_W'(row_reg);
            keep   = (CMP_W'(col_reg) < CMP_W'(TILE_SIDE)) &&
                     (CMP_W'(row_reg) < CMP_W'(TILE_SIDE)) &&
                     (x_wide < CMP_W'(w_clamp)) && (y_wide < CMP_W'(h_clamp));
        end else begin
            x_wide = CMP_W'(col_reg);
            y_wide = CMP_W'(row_reg);
            keep   = (x_wide < CMP_W'(w_clamp)) && (y_wide < CMP_W'(h_clamp));
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        tcb_next = tcb_reg;
        trb_next = trb_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
            tcb_next = '0;
            trb_next = '0;
        end else if (s_accept) begin
            if (tiled_reg) begin
                if (CMP_W'(col_reg) + CMP_W'(1) >= CMP_W'(TILE_SIDE)) begin
                    col_next = '0;
                    if (CMP_W'(row_reg) + CMP_W'(1) >= CMP_W'(TILE_SIDE)) begin
                        row_next = '0;
                        // next tile to the right, or first tile of next tile row
                        if (CMP_W'(tcb_reg) + CMP_W'(TILE_SIDE) >= CMP_W'(w_clamp)) begin
                            tcb_next = '0;
                            if (CMP_W'(trb_reg) + CMP_W'(TILE_SIDE) >= CMP_W'(h_clamp)) begin
                                trb_next = '0;
                            end else begin
                                trb_next = POS_W'(CMP_W'(trb_reg) + CMP_W'(TILE_SIDE));
                            end
                        end else begin
                            tcb_next = POS_W'(CMP_W'(tcb_reg) + CMP_W'(TILE_SIDE));
                        end
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else begin
                if (CMP_W'(col_reg) + CMP_W'(1) >= CMP_W'(pitch_eff)) begin
                    col_next = '0;
                    if (CMP_W'(row_reg) + CMP_W'(1) >= CMP_W'(h_clamp)) begin
                        row_next = '0;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    // ---------------- configuration and counters ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= tsbd_pkg::FMT_RGBA4444;
            tiled_reg  <= 1'b0;
            width_reg  <= tsbd_pkg::DIM_REG_W'(1);
            height_reg <= tsbd_pkg::DIM_REG_W'(1);
            pitch_reg  <= tsbd_pkg::PITCH_REG_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            tcb_reg    <= '0;
            trb_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tsbd_pkg::REG_PIXEL_FORMAT: begin
                        format_reg <= tsbd_pkg::pixel_format_t'(cfg_wdata[tsbd_pkg::FORMAT_W-1:0]);
                    end
                    tsbd_pkg::REG_TILED_LAYOUT: tiled_reg <= cfg_wdata[0];
                    tsbd_pkg::REG_IMAGE_WIDTH:  width_reg <= cfg_wdata[tsbd_pkg::DIM_REG_W-1:0];
                    tsbd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[tsbd_pkg::DIM_REG_W-1:0];
                    tsbd_pkg::REG_ROW_PITCH:    pitch_reg <= cfg_wdata[tsbd_pkg::PITCH_REG_W-1:0];
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            tcb_reg <= tcb_next;
            trb_reg <= trb_next;
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= keep;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_word_reg <= s_texel_word;
            s1_x_reg    <= x_wide[POS_W-1:0];
            s1_y_reg    <= y_wide[POS_W-1:0];
        end
    end

    // ---------------- decode ----------------
    always_comb begin
        case (format_reg)
            tsbd_pkg::FMT_RGBA8888: begin
                dec_r = s1_word_reg[7:0];
                dec_g = s1_word_reg[15:8];
                dec_b = s1_word_reg[23:16];
                dec_a = s1_word_reg[31:24];
            end
            tsbd_pkg::FMT_RGBA4444: begin
                dec_a = tsbd_pkg::rep4(s1_word_reg[3:0]);
                dec_b = tsbd_pkg::rep4(s1_word_reg[7:4]);
                dec_g = tsbd_pkg::rep4(s1_word_reg[11:8]);
                dec_r = tsbd_pkg::rep4(s1_word_reg[15:12]);
            end
            tsbd_pkg::FMT_RGB565: begin
                dec_b = tsbd_pkg::rep5(s1_word_reg[4:0]);
                dec_g = tsbd_pkg::rep6(s1_word_reg[10:5]);
                dec_r = tsbd_pkg::rep5(s1_word_reg[15:11]);
                dec_a = tsbd_pkg::ALPHA_OPAQUE;
            end
            default: begin
                dec_a = s1_word_reg[0] ? tsbd_pkg::ALPHA_OPAQUE : tsbd_pkg::ALPHA_CLEAR;
                dec_b = tsbd_pkg::rep5(s1_word_reg[5:1]);
                dec_g = tsbd_pkg::rep5(s1_word_reg[10:6]);
                dec_r = tsbd_pkg::rep5(s1_word_reg[15:11]);
            end
        endcase
    end

    assign index_full = IDX_W'(s1_y_reg) * IDX_W'(w_clamp) + IDX_W'(s1_x_reg);

    // ---------------- output stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_index_reg <= tsbd_pkg::INDEX_W'(index_full);
            m_blue_reg  <= dec_b;
            m_green_reg <= dec_g;
            m_red_reg   <= dec_r;
            m_alpha_reg <= dec_a;
            m_end_reg   <= (DIM_W'(s1_x_reg) == w_clamp - DIM_W'(1)) &&
                           (DIM_W'(s1_y_reg) == h_clamp - DIM_W'(1));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = m_index_reg;
    assign m_blue        = m_blue_reg;
    assign m_green       = m_green_reg;
    assign m_red         = m_red_reg;
    assign m_alpha       = m_alpha_reg;
    assign m_image_end   = m_end_reg;

    // ---------------- assertions ----------------
    // input stalls only when both stages hold a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg))
        else $error("s_ready low with a free stage");

    // linear walk stays inside the pitch and the image rows
    assert property (@(posedge aclk) disable iff (!aresetn)
        !tiled_reg |-> (CMP_W'(col_reg) < CMP_W'(pitch_eff)) &&
                       (CMP_W'(row_reg) < CMP_W'(h_clamp)))
        else $error("linear counters out of range");

    // tiled walk stays inside a tile
    assert property (@(posedge aclk) disable iff (!aresetn)
        tiled_reg |-> (CMP_W'(col_reg) < CMP_W'(TILE_SIDE)) &&
                      (CMP_W'(row_reg) < CMP_W'(TILE_SIDE)))
        else $error("tile counters out of range");

    // a register write restarts the walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (col_reg == '0) && (row_reg == '0) && (tcb_reg == '0) && (trb_reg == '0))
        else $error("counters not cleared by register write");

    // the last pixel of the image carries index width * height - 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_end_reg) |->
            m_index_reg == tsbd_pkg::INDEX_W'(AREA_W'(w_clamp) * AREA_W'(h_clamp)
                                              - AREA_W'(1)))
        else $error("image end flag on wrong pixel index");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the texel stream to BGRA8888 decoder core.
module tb_top;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_SETTLE = 4;
    localparam int ITEM_TARGET  = 550;
    localparam int TILE         = tsbd_pkg::DEFAULT_TILE_SIDE;
    localparam int MAX_DIM      = tsbd_pkg::DEFAULT_MAX_DIMENSION;

    // indexes past the register list; the block must ignore them
    localparam logic [tsbd_pkg::CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [tsbd_pkg::CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [tsbd_pkg::INDEX_W-1:0]   index;
        logic [tsbd_pkg::CHANNEL_W-1:0] blue;
        logic [tsbd_pkg::CHANNEL_W-1:0] green;
        logic [tsbd_pkg::CHANNEL_W-1:0] red;
        logic [tsbd_pkg::CHANNEL_W-1:0] alpha;
        logic                           image_end;
    } bgra_pixel_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [tsbd_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [tsbd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [tsbd_pkg::TEXEL_W-1:0]     s_texel_word;
    logic                             m_valid;
    logic                             m_ready;
    logic [tsbd_pkg::INDEX_W-1:0]     m_pixel_index;
    logic [tsbd_pkg::CHANNEL_W-1:0]   m_blue;
    logic [tsbd_pkg::CHANNEL_W-1:0]   m_green;
    logic [tsbd_pkg::CHANNEL_W-1:0]   m_red;
    logic [tsbd_pkg::CHANNEL_W-1:0]   m_alpha;
    logic                             m_image_end;

    // decoder state as the testbench sees it
    tsbd_pkg::pixel_format_t          cur_format;
    logic                             cur_tiled;
    logic [tsbd_pkg::DIM_REG_W-1:0]   width_reg;
    logic [tsbd_pkg::DIM_REG_W-1:0]   height_reg;
    logic [tsbd_pkg::PITCH_REG_W-1:0] pitch_reg;
    int                               walk_col;
    int                               walk_row;
    int                               tile_x0;
    int                               tile_y0;

    bgra_pixel_t            pending_pixels[$];
    bgra_pixel_t            head_pixel;
    int                     words_sent;
    int                     err_count;
    int                     quiet_cycles;
    int                     sink_hold;
    bit                     sink_burst;
    bit                     src_burst;

    texel_stream_to_bgra_decoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_texel_word  (s_texel_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_blue        (m_blue),
        .m_green       (m_green),
        .m_red         (m_red),
        .m_alpha       (m_alpha),
        .m_image_end   (m_image_end)
    );

    always #1 aclk = ~aclk;

    function automatic int effective_dim(input int v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void reset_walk();
        walk_col = 0;
        walk_row = 0;
        tile_x0  = 0;
        tile_y0  = 0;
    endfunction

    function automatic void apply_reg_write(input logic [tsbd_pkg::CFG_ADDR_W-1:0] idx,
                                            input logic [tsbd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tsbd_pkg::REG_PIXEL_FORMAT:
                cur_format = tsbd_pkg::pixel_format_t'(data[tsbd_pkg::FORMAT_W-1:0]);
            tsbd_pkg::REG_TILED_LAYOUT: cur_tiled  = data[0];
            tsbd_pkg::REG_IMAGE_WIDTH:  width_reg  = data[tsbd_pkg::DIM_REG_W-1:0];
            tsbd_pkg::REG_IMAGE_HEIGHT: height_reg = data[tsbd_pkg::DIM_REG_W-1:0];
            tsbd_pkg::REG_ROW_PITCH:    pitch_reg  = data[tsbd_pkg::PITCH_REG_W-1:0];
            default: return;
        endcase
        reset_walk();
    endfunction

    // Advance the address walk by one stored word; queue a pixel if it lands in the image.
    function automatic void predict_pixel(input logic [tsbd_pkg::TEXEL_W-1:0] word);
        int w, h, pitch, x, y;
        bit keep;
        logic [31:0] flat;
        bgra_pixel_t px;
        w = effective_dim(int'(width_reg));
        h = effective_dim(int'(height_reg));
        if (cur_tiled) begin
            x = tile_x0 + walk_col;
            y = tile_y0 + walk_row;
            keep = walk_col < TILE && walk_row < TILE && x < w && y < h;
            walk_col++;
            if (walk_col >= TILE) begin
                walk_col = 0;
                walk_row++;
                if (walk_row >= TILE) begin
                    walk_row = 0;
                    tile_x0 += TILE;
                    if (tile_x0 >= w) begin
                        tile_x0 = 0;
                        tile_y0 += TILE;
                        if (tile_y0 >= h) tile_y0 = 0;
                    end
                end
            end
        end else begin
            pitch = int'(pitch_reg);
            if (pitch < w) pitch = w;
            if (pitch > 2 * MAX_DIM) pitch = 2 * MAX_DIM;
            x = walk_col;
            y = walk_row;
            keep = x < w && y < h;
            walk_col++;
            if (walk_col >= pitch) begin
                walk_col = 0;
                walk_row++;
                if (walk_row >= h) walk_row = 0;
            end
        end
        if (!keep) return;

        case (cur_format)
            tsbd_pkg::FMT_RGBA8888: {px.alpha, px.blue, px.green, px.red} = word;
            tsbd_pkg::FMT_RGBA4444: begin
                px.alpha = {2{word[3:0]}};
                px.blue  = {2{word[7:4]}};
                px.green = {2{word[11:8]}};
                px.red   = {2{word[15:12]}};
            end
            tsbd_pkg::FMT_RGB565: begin
                px.blue  = {word[4:0], word[4:2]};
                px.green = {word[10:5], word[10:9]};
                px.red   = {word[15:11], word[15:13]};
                px.alpha = tsbd_pkg::ALPHA_OPAQUE;
            end
            default: begin
                px.alpha = word[0] ? tsbd_pkg::ALPHA_OPAQUE : tsbd_pkg::ALPHA_CLEAR;
                px.blue  = {word[5:1], word[5:3]};
                px.green = {word[10:6], word[10:8]};
                px.red   = {word[15:11], word[15:13]};
            end
        endcase
        flat = y * w + x;
        px.index = flat[tsbd_pkg::INDEX_W-1:0];
        px.image_end = (x == w - 1) && (y == h - 1);
        pending_pixels.push_back(px);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // result checking, register and word tracking, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none actual index %h",
                             $time, m_pixel_index);
                    err_count++;
                end else begin
                    head_pixel = pending_pixels.pop_front();
                    check_field("pixel_index", 32'(head_pixel.index), 32'(m_pixel_index));
                    check_field("blue", 32'(head_pixel.blue), 32'(m_blue));
                    check_field("green", 32'(head_pixel.green), 32'(m_green));
                    check_field("red", 32'(head_pixel.red), 32'(m_red));
                    check_field("alpha", 32'(head_pixel.alpha), 32'(m_alpha));
                    check_field("image_end", 32'(head_pixel.image_end), 32'(m_image_end));
                end
                sink_hold <= sink_burst ? 0 : $urandom_range(0, 9);
            end
            if (cfg_wr_en) apply_reg_write(cfg_addr, cfg_wdata);
            if (s_valid && s_ready) predict_pixel(s_texel_word);

            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Entered just after a rising edge; valid stays up across back-to-back words.
    task automatic send_texel(input logic [tsbd_pkg::TEXEL_W-1:0] word);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        words_sent++;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_texel_word <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait out every pending pixel plus the pipeline depth, since dropped words leave no trace.
    task automatic drain_pixels();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tsbd_pkg::CFG_ADDR_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[tsbd_pkg::CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input tsbd_pkg::pixel_format_t fmt, input bit tiled, input int w,
                             input int h, input int pitch);
        drain_pixels();
        write_reg(tsbd_pkg::REG_PIXEL_FORMAT, int'(fmt));
        write_reg(tsbd_pkg::REG_TILED_LAYOUT, int'(tiled));
        write_reg(tsbd_pkg::REG_IMAGE_WIDTH, w);
        write_reg(tsbd_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(tsbd_pkg::REG_ROW_PITCH, pitch);
    endtask

    // 1x1 RGBA4444 image after reset: every word is the last pixel
    task automatic test_reset_defaults();
        src_burst  = 1'b0;
        sink_burst = 1'b0;
        send_texel(32'h0000_0000);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h1234_A5C3);
    endtask

    task automatic test_pixel_formats();
        for (int f = 0; f < 4; f++) begin
            configure(tsbd_pkg::pixel_format_t'(f), 1'b0, 2, 2, 2);
            send_texel(32'h0000_0000);
            send_texel(32'hFFFF_FFFF);
            send_texel(32'h1234_5678);
            send_texel(32'hEDCB_A987);
        end
    endtask

    task automatic test_walk_corners();
        // width write with bit 13 set, zero pitch falls back to the width
        configure(tsbd_pkg::FMT_RGB565, 1'b0, 'h2003, 2, 0);
        repeat (4) send_texel($urandom());
        drain_pixels();
        write_reg(REG_SPARE_FIRST, 16383);
        repeat (3) send_texel($urandom());
        // zero dimensions clamp up to one pixel
        configure(tsbd_pkg::FMT_RGBA4444, 1'b0, 0, 0, 9);
        repeat (2) send_texel($urandom());
        // oversized dimensions clamp down to the maximum
        configure(tsbd_pkg::FMT_RGBA8888, 1'b0, 8191, 8191, 5);
        repeat (2) send_texel($urandom());
    endtask

    // pitch far above the width: the rest of a long row is dropped
    task automatic test_pitch_clamp();
        configure(tsbd_pkg::FMT_RGBA8888, 1'b0, 3, 2, 16383);
        src_burst = 1'b1;
        repeat (24) send_texel($urandom());
        src_burst = 1'b0;
    endtask

    // partial first tile: columns past the width are dropped
    task automatic test_tiled_walk();
        configure(tsbd_pkg::FMT_RGBA5551, 1'b1, 20, 5, 1);
        repeat (5 * TILE) send_texel($urandom());
    endtask

    task automatic test_random_images();
        int w, h, pitch, we, he, pe, n, sel;
        bit tiled, stray;
        while (words_sent < ITEM_TARGET) begin
            tiled = ($urandom_range(0, 4) == 0);
            if (tiled) begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 36);
                pitch = $urandom_range(0, 16383);
                n = $urandom_range(16, 80);
            end else begin
                sel = $urandom_range(0, 19);
                w = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(MAX_DIM, 8191)
                                                : $urandom_range(1, 12);
                sel = $urandom_range(0, 19);
                h = (sel == 0) ? 0 : (sel == 1) ? 8191 : $urandom_range(1, 6);
                we = effective_dim(w);
                he = effective_dim(h);
                sel = $urandom_range(0, 9);
                pitch = (sel < 4) ? $urandom_range(0, we) :
                        (sel < 9) ? we + $urandom_range(0, 4) : $urandom_range(0, 16383);
                pe = (pitch < we) ? we : (pitch > 2 * MAX_DIM) ? 2 * MAX_DIM : pitch;
                n = pe * he * 2 + $urandom_range(0, 5);
                if (n > 60) n = 60;
            end
            configure(tsbd_pkg::pixel_format_t'($urandom_range(0, 3)), tiled, w, h, pitch);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            stray = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < n; i++) begin
                if (stray && i == n / 2) begin
                    drain_pixels();
                    write_reg(tsbd_pkg::CFG_ADDR_W'(32'(REG_SPARE_FIRST) +
                              $urandom_range(0, 32'(REG_SPARE_LAST - REG_SPARE_FIRST))),
                              $urandom_range(0, 16383));
                end
                send_texel($urandom());
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_addr         = tsbd_pkg::REG_PIXEL_FORMAT;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_texel_word     = '0;
        m_ready          = 1'b0;
        sink_hold        = 0;
        sink_burst       = 1'b0;
        src_burst        = 1'b0;
        err_count        = 0;
        quiet_cycles     = 0;
        words_sent       = 0;
        cur_format       = tsbd_pkg::FMT_RGBA4444;
        cur_tiled        = 1'b0;
        width_reg        = 1;
        height_reg       = 1;
        pitch_reg        = 1;
        reset_walk();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_pixel_formats();
        test_walk_corners();
        test_pitch_clamp();
        test_tiled_walk();
        test_random_images();
        drain_pixels();

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
rtl/tsbd_pkg.sv
rtl/texel_stream_to_bgra_decoder_core.sv
tb/tb_top.sv
